[design/ohfp_pkg.sv]
package ohfp_pkg;

  localparam int ValueW = 64;
  localparam int CharW  = 8;

  typedef logic [CharW-1:0] char_t;

  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_DIGITS = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_BAD    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  localparam char_t ChX    = 8'h78;
  localparam char_t ChNul  = 8'h00;
  localparam char_t Ch0    = 8'h30;
  localparam char_t ChLowA = 8'h61;
  localparam char_t ChUpA  = 8'h41;

  function automatic logic is_ws(input char_t c);
    logic r;
    r = 1'b0;
    case (c) inside
      8'h20, [8'h09:8'h0D]: r = 1'b1;
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic digit_t digit_of(input char_t c, input logic hex);
    digit_t d;
    char_t  t;
    d.ok  = 1'b0;
    d.val = 4'd0;
    t     = '0;
    case (c) inside
      [8'h30:8'h37]: begin
        t     = c - Ch0;
        d.ok  = 1'b1;
        d.val = t[3:0];
      end
      [8'h38:8'h39]: begin
        t     = c - Ch0;
        d.ok  = hex;
        d.val = t[3:0];
      end
      [8'h61:8'h66]: begin
        t     = c - ChLowA + 8'd10;
        d.ok  = hex;
        d.val = t[3:0];
      end
      [8'h41:8'h46]: begin
        t     = c - ChUpA + 8'd10;
        d.ok  = hex;
        d.val = t[3:0];
      end
      default: begin
        d.ok  = 1'b0;
        d.val = 4'd0;
      end
    endcase
    return d;
  endfunction

endpackage

[design/octal_hex_field_parser.sv]
// A field's result appears in the cycle after its last character is accepted.
// Throughput: one character per cycle; the single result register is refilled
// in the same cycle it is read, so the input stalls only while a result waits.
// Reset (rst_n low, synchronous): parser returns to the start of a field and
// the result register empties.
module octal_hex_field_parser
  import ohfp_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] ch
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ValueW-1:0] out_tdata,  // [63:0] value
  output logic [0:0]        out_tuser   // [0] invalid
);

  localparam logic [ValueW-1:0] BadValue = ValueW'({VALUE_BITS{1'b1}});

  logic                  at_start_r, at_start_nxt;
  logic                  hex_r, hex_nxt;
  phase_t                phase_r, phase_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  out_valid_r;
  logic [ValueW-1:0]     out_value_r;
  logic                  out_bad_r;

  logic                  in_acc;
  char_t                 c;
  logic                  hex_cur;
  phase_t                phase_cur;
  logic [VALUE_BITS-1:0] acc_cur;
  digit_t                dg;
  logic                  res_bad;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign c         = in_tdata;

  assign hex_cur   = at_start_r ? 1'b0 : hex_r;
  assign phase_cur = at_start_r ? PH_SKIP : phase_r;
  assign acc_cur   = at_start_r ? '0 : acc_r;

  always_comb begin
    at_start_nxt = 1'b0;
    hex_nxt      = hex_cur;
    phase_nxt    = phase_cur;
    acc_nxt      = acc_cur;
    res_bad      = 1'b0;
    dg           = digit_of(c, hex_cur);
    if (at_start_r && c == ChX) begin
      hex_nxt = 1'b1;
    end else begin
      if (phase_cur == PH_SKIP && is_ws(c)) begin
        phase_nxt = PH_SKIP;
        res_bad   = 1'b1;
      end else if (phase_cur == PH_SKIP || phase_cur == PH_DIGITS) begin
        if (dg.ok) begin
          phase_nxt = PH_DIGITS;
          acc_nxt   = hex_cur ? {acc_cur[VALUE_BITS-5:0], dg.val}
                              : {acc_cur[VALUE_BITS-4:0], dg.val[2:0]};
        end else if (c == ChNul || is_ws(c)) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      if (phase_nxt == PH_BAD) begin
        res_bad = 1'b1;
      end
    end
    if (in_tlast) begin
      at_start_nxt = 1'b1;
      hex_nxt      = 1'b0;
      phase_nxt    = PH_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      hex_r      <= 1'b0;
      phase_r    <= PH_SKIP;
      acc_r      <= '0;
    end else if (in_acc) begin
      at_start_r <= at_start_nxt;
      hex_r      <= hex_nxt;
      phase_r    <= phase_nxt;
      acc_r      <= in_tlast ? '0 : acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      out_bad_r   <= res_bad;
      out_value_r <= res_bad ? BadValue : ValueW'(acc_nxt);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_bad_r;

  a_bad_is_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == BadValue)
    else $error("invalid result without all-ones value");

  a_value_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata & ~BadValue) == '0)
    else $error("result value exceeds VALUE_BITS");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> at_start_r && out_tvalid)
    else $error("last character did not close the field");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !(in_acc && in_tlast) |=> !out_tvalid)
    else $error("result without a last character");

endmodule
